@@ hdl/bpm_pkg.sv @@
// Shared codes, defaults and cell control type of the breakpoint match unit.
package bpm_pkg;

  localparam int SLOTS_DEF     = 32;
  localparam int ADDR_BITS_DEF = 32;

  localparam int FUNC_W   = 3;
  localparam int IN_ADDR_W = 32;
  localparam int BTYPE_W  = 3;
  localparam int STATUS_W = 2;
  localparam int USED_W   = 6;

  localparam logic [FUNC_W-1:0] OP_CHECK    = 3'd0;
  localparam logic [FUNC_W-1:0] OP_INSERT   = 3'd1;
  localparam logic [FUNC_W-1:0] OP_REMOVE   = 3'd2;
  localparam logic [FUNC_W-1:0] OP_CONTINUE = 3'd3;
  localparam logic [FUNC_W-1:0] OP_STEP     = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL        = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNSUPPORTED = 2'd2;

  localparam logic [BTYPE_W-1:0] BT_SOFTWARE = 3'd0;

  // Per-cell load select: take the left neighbor (insert) or the right one (remove).
  typedef struct packed {
    logic shift_up;
    logic shift_down;
  } cell_ctl_t;

endpackage

@@ hdl/bpm_cell.sv @@
// One breakpoint slot: address register, neighbor load mux and comparator.
module bpm_cell #(
  parameter int ADDR_BITS = bpm_pkg::ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  bpm_pkg::cell_ctl_t   ctl,
  input  logic [ADDR_BITS-1:0] from_left,
  input  logic [ADDR_BITS-1:0] from_right,
  input  logic [ADDR_BITS-1:0] key,
  output logic [ADDR_BITS-1:0] addr,
  output logic                 hit
);
  import bpm_pkg::*;

  logic [ADDR_BITS-1:0] addr_r;
  logic [ADDR_BITS-1:0] addr_nxt;

  always_comb begin
    priority if (ctl.shift_up) begin
      addr_nxt = from_left;
    end else if (ctl.shift_down) begin
      addr_nxt = from_right;
    end else begin
      addr_nxt = addr_r;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
  end

  assign addr = addr_r;
  assign hit  = (addr_r == key);

endmodule

@@ hdl/breakpoint_match_unit.sv @@
// Top level of the breakpoint match unit: cell chain, count, step flag, result stage.
// Usage
//   Input beat: drive in_func, in_address and in_break_type with start high; the
//   beat is taken at a rising edge where start is high and busy is low.
//   Result beat: out_valid is high for exactly one cycle with out_stop,
//   out_status and out_entries_used; the receiver cannot stall, so take it then.
//   Config: cfg_we with cfg_wdata sets debugger_attached; write only when idle.
// Results and rate
//   Every beat yields one result: out_valid rises at the edge after the accepting
//   edge. All beats except a software remove are taken every cycle. A software
//   remove holds busy for the next cycle; the chain shifts down past the removed
//   slot at the end of it, and the next compare has to see it.
// Structure
//   A row of SLOTS cells, each one address register and comparator. Insert
//   shifts the row up one cell with the new address entering cell 0; remove
//   shifts every cell from the lowest match upward down by one. Slots at and
//   above entry_count hold stale data and are masked out of every compare.
// Reset
//   rst_n (synchronous) clears the entry count, step flag, debugger_attached
//   and the pipeline valids. Cell contents are not reset.
module breakpoint_match_unit #(
  parameter int SLOTS     = bpm_pkg::SLOTS_DEF,
  parameter int ADDR_BITS = bpm_pkg::ADDR_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [bpm_pkg::FUNC_W-1:0]     in_func,
  input  logic [bpm_pkg::IN_ADDR_W-1:0]  in_address,
  input  logic [bpm_pkg::BTYPE_W-1:0]    in_break_type,
  output logic                           out_valid,
  output logic                           out_stop,
  output logic [bpm_pkg::STATUS_W-1:0]   out_status,
  output logic [bpm_pkg::USED_W-1:0]     out_entries_used,
  input  logic                           cfg_we,
  input  logic                           cfg_wdata
);
  import bpm_pkg::*;

  localparam int CW = $clog2(SLOTS + 1);

  // control state
  logic [CW-1:0]       count_r, count_nxt;
  logic                step_r, step_nxt;
  logic                attached_r;
  logic                s1_valid_r;
  logic                out_valid_r;

  // stage 1 payload
  logic [FUNC_W-1:0]   s1_func_r;
  logic [STATUS_W-1:0] s1_status_r, s1_status_nxt;
  logic                s1_rm_r;
  logic [SLOTS-1:0]    s1_hit_r;

  // result payload
  logic                out_stop_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [USED_W-1:0]   out_used_r;

  logic                 accept;
  logic                 is_sw;
  logic                 do_insert;
  logic                 any_hit;
  logic                 rm_go;
  logic [SLOTS-1:0]     below;
  logic [ADDR_BITS-1:0] key;
  logic [SLOTS-1:0]     hit;
  logic [SLOTS-1:0]     live;
  logic [ADDR_BITS-1:0] cell_addr [SLOTS];
  cell_ctl_t            cell_ctl  [SLOTS];

  // A pending software remove must shift the chain before the next compare.
  assign busy   = s1_valid_r && s1_rm_r;
  assign accept = start && !busy;

  assign key       = ADDR_BITS'(in_address);
  assign is_sw     = (in_break_type == BT_SOFTWARE);
  assign do_insert = accept && (in_func == OP_INSERT) && is_sw && (count_r < CW'(SLOTS));

  // Lowest match in stage 1: everything at and above it moves down one cell.
  assign any_hit = |s1_hit_r;
  assign rm_go   = s1_valid_r && s1_rm_r && any_hit;
  assign below   = (s1_hit_r - SLOTS'(1)) & ~s1_hit_r;

  genvar gi;
  generate
    for (gi = 0; gi < SLOTS; gi++) begin : g_cell
      logic [ADDR_BITS-1:0] left_addr;
      logic [ADDR_BITS-1:0] right_addr;

      if (gi == 0) begin : g_head
        assign left_addr = key;
      end else begin : g_body
        assign left_addr = cell_addr[gi-1];
      end

      if (gi == SLOTS - 1) begin : g_tail
        assign right_addr = cell_addr[gi];
      end else begin : g_inner
        assign right_addr = cell_addr[gi+1];
      end

      assign live[gi]                = (CW'(gi) < count_r);
      assign cell_ctl[gi].shift_up   = do_insert;
      assign cell_ctl[gi].shift_down = rm_go && !below[gi];

      bpm_cell #(
        .ADDR_BITS (ADDR_BITS)
      ) u_cell (
        .clk        (clk),
        .ctl        (cell_ctl[gi]),
        .from_left  (left_addr),
        .from_right (right_addr),
        .key        (key),
        .addr       (cell_addr[gi]),
        .hit        (hit[gi])
      );
    end
  endgenerate

  // Status of the accepted beat, known at accept time.
  always_comb begin
    s1_status_nxt = ST_OK;
    unique case (in_func)
      OP_INSERT: begin
        priority if (!is_sw) begin
          s1_status_nxt = ST_UNSUPPORTED;
        end else if (count_r >= CW'(SLOTS)) begin
          s1_status_nxt = ST_FULL;
        end else begin
          s1_status_nxt = ST_OK;
        end
      end
      OP_REMOVE: begin
        s1_status_nxt = is_sw ? ST_OK : ST_UNSUPPORTED;
      end
      default: begin
        s1_status_nxt = ST_OK;
      end
    endcase
  end

  // Insert and a completing remove never share an edge: busy blocks it.
  always_comb begin
    priority if (do_insert) begin
      count_nxt = count_r + CW'(1);
    end else if (rm_go) begin
      count_nxt = count_r - CW'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  always_comb begin
    step_nxt = step_r;
    if (accept && (in_func == OP_CONTINUE)) begin
      step_nxt = 1'b0;
    end else if (accept && (in_func == OP_STEP)) begin
      step_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      step_r      <= 1'b0;
      attached_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      s1_valid_r  <= accept;
      out_valid_r <= s1_valid_r;
      if (cfg_we) begin
        attached_r <= cfg_wdata;
      end
    end
  end

  // Stage 1: hold the masked match vector and the beat's decode.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func_r   <= in_func;
      s1_status_r <= s1_status_nxt;
      s1_rm_r     <= (in_func == OP_REMOVE) && is_sw;
      s1_hit_r    <= hit & live;
    end
  end

  // Result stage: count is read before any later insert lands.
  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      out_stop_r   <= (s1_func_r == OP_CHECK) && attached_r && (step_r || any_hit);
      out_status_r <= s1_status_r;
      out_used_r   <= USED_W'(rm_go ? (count_r - CW'(1)) : count_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_stop         = out_stop_r;
  assign out_status       = out_status_r;
  assign out_entries_used = out_used_r;

  // Every accepted beat yields a result: a stage 1 valid is always followed by out_valid.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |=> out_valid)
    else $error("accepted beat produced no result");

  // Table never grows past its slot count.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(SLOTS))
    else $error("entry count exceeds slot count");

  // A full report always carries a full table.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL)) |-> (out_entries_used == USED_W'(SLOTS)))
    else $error("table full reported with free slots");

  // An accepted software remove raises busy in the next cycle, stalling the next beat.
  a_remove_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_func == OP_REMOVE) && is_sw) |=> busy)
    else $error("remove did not hold busy");

endmodule
